// ===== rtl/core/apnn_pkg.sv =====
package apnn_pkg;

    localparam int MAX_VECTORS_DEF    = 64;
    localparam int MAX_DIM_DEF        = 16;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int CFG_BITS           = 5;

    typedef struct packed {
        logic first_k;
        logic last_k;
        logic cand_first;
    } apnn_tag_t;

endpackage

// ===== rtl/core/all_pairs_nearest_neighbour.sv =====
// Brute-force nearest neighbour by exact squared Euclidean distance. Components stream in
// one per accepted word; the word marked last closes the set. The block then counts complete
// vectors, and for each vector loads it into a rotating row of cells, sweeps all candidates
// one component per cycle through a single subtract-square-accumulate pipeline, drains it and
// presents one result, held until taken. The sweep is bounded by the one read port of the
// vector memory. No input is taken until the last result of a set has been delivered.
module all_pairs_nearest_neighbour
    import apnn_pkg::*;
#(
    parameter int MAX_VECTORS    = MAX_VECTORS_DEF,
    parameter int MAX_DIM        = MAX_DIM_DEF,
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    localparam int IW = $clog2(MAX_VECTORS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vector_dim_wr_en,
    input  logic [CFG_BITS-1:0]              vector_dim,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COMPONENT_BITS-1:0] component_value,
    input  logic                             last_component,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [IW-1:0]                    source_index,
    output logic [IW-1:0]                    nearest_index,
    output logic                             last_result
);

    localparam int DEPTH = MAX_VECTORS * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = $clog2(MAX_VECTORS + 1);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int W     = COMPONENT_BITS;

    typedef enum logic [2:0] {IDLE, COUNT, LOADQ, SCAN, DRAIN, OUT} state_t;

    state_t              state_reg;
    logic [CFG_BITS-1:0] vdim_reg;
    logic [CW-1:0]       count_reg, rem_reg;
    logic [DIM_W-1:0]    dim_reg, k_reg;
    logic [VW-1:0]       nv_reg, j_reg;
    logic [IW-1:0]       i_reg;
    logic                cand_first_reg;
    logic                out_valid_reg, last_result_reg;
    logic [IW-1:0]       src_reg, near_reg;
    logic                rd_valid_reg, rd_load_reg;
    apnn_tag_t           rd_tag_reg;
    logic [IW-1:0]       rd_j_reg;
    logic signed [W-1:0] rd_data_reg;
    logic signed [W-1:0] mem [DEPTH];

    logic [DIM_W-1:0]    dim_eff;
    logic                in_acc, full;
    logic [CW-1:0]       count_inc;
    logic                iss_valid, iss_load;
    logic [VW-1:0]       iss_vec;
    apnn_tag_t           iss_tag;
    logic [AW-1:0]       iss_addr;
    logic [VW-1:0]       jb, jn, i_next;
    logic                dist_busy;
    logic [IW-1:0]       best_idx;
    logic signed [W-1:0] cell_val [MAX_DIM];

    assign in_acc    = in_valid && in_ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign count_inc = full ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        if (vdim_reg == '0)
            dim_eff = DIM_W'(1);
        else if (int'(vdim_reg) > MAX_DIM)
            dim_eff = DIM_W'(MAX_DIM);
        else
            dim_eff = DIM_W'(vdim_reg);
    end

    assign i_next = (VW'(i_reg) + 1'b1 == nv_reg) ? '0 : VW'(i_reg) + 1'b1;
    assign jb     = cand_first_reg ? '0 : j_reg + 1'b1;
    assign jn     = (jb == VW'(i_reg)) ? jb + 1'b1 : jb;

    always_comb
    begin
        iss_valid = (state_reg == LOADQ) || (state_reg == SCAN);
        iss_load  = (state_reg == LOADQ);
        iss_vec   = iss_load ? VW'(i_reg) : j_reg;
        iss_tag.first_k    = (k_reg == '0);
        iss_tag.last_k     = (k_reg == dim_reg - 1'b1);
        iss_tag.cand_first = cand_first_reg;
        iss_addr  = AW'(AW'(iss_vec) * AW'(dim_reg) + AW'(k_reg));
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !full)
            mem[AW'(count_reg)] <= component_value;
    end

    always_ff @(posedge clk)
    begin
        if (iss_valid)
            rd_data_reg <= mem[iss_addr];
        rd_tag_reg <= iss_tag;
        rd_j_reg   <= IW'(j_reg);
        rd_load_reg <= iss_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            vdim_reg        <= CFG_BITS'(1);
            count_reg       <= '0;
            rem_reg         <= '0;
            dim_reg         <= DIM_W'(1);
            k_reg           <= '0;
            nv_reg          <= '0;
            j_reg           <= '0;
            i_reg           <= '0;
            cand_first_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_result_reg <= 1'b0;
            src_reg         <= '0;
            near_reg        <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (vector_dim_wr_en)
                vdim_reg <= vector_dim;
            rd_valid_reg <= iss_valid;
            unique case (state_reg)
                IDLE:
                begin
                    if (in_acc)
                    begin
                        if (last_component)
                        begin
                            count_reg <= '0;
                            rem_reg   <= count_inc;
                            dim_reg   <= dim_eff;
                            nv_reg    <= '0;
                            state_reg <= COUNT;
                        end
                        else
                            count_reg <= count_inc;
                    end
                end
                COUNT:
                begin
                    if (rem_reg >= CW'(dim_reg) && nv_reg != VW'(MAX_VECTORS))
                    begin
                        rem_reg <= rem_reg - CW'(dim_reg);
                        nv_reg  <= nv_reg + 1'b1;
                    end
                    else if (nv_reg == '0)
                        state_reg <= IDLE;
                    else
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= LOADQ;
                    end
                end
                LOADQ:
                begin
                    if (k_reg == dim_reg - 1'b1)
                    begin
                        k_reg          <= '0;
                        j_reg          <= i_next;
                        cand_first_reg <= 1'b1;
                        state_reg      <= SCAN;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                SCAN:
                begin
                    if (k_reg == dim_reg - 1'b1)
                    begin
                        k_reg          <= '0;
                        cand_first_reg <= 1'b0;
                        j_reg          <= jn;
                        if (jn >= nv_reg)
                            state_reg <= DRAIN;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                DRAIN:
                begin
                    if (!rd_valid_reg && !dist_busy)
                    begin
                        out_valid_reg   <= 1'b1;
                        src_reg         <= i_reg;
                        near_reg        <= best_idx;
                        last_result_reg <= (VW'(i_reg) + 1'b1 == nv_reg);
                        state_reg       <= OUT;
                    end
                end
                OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_result_reg)
                            state_reg <= IDLE;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            k_reg     <= '0;
                            state_reg <= LOADQ;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    for (genvar m = 0; m < MAX_DIM; m++)
    begin : g_cell
        logic signed [W-1:0] nxt;
        if (m == MAX_DIM - 1)
        begin : g_end
            assign nxt = '0;
        end
        else
        begin : g_mid
            assign nxt = cell_val[m+1];
        end
        apnn_cell #(.W(W)) u_cell (
            .clk      (clk),
            .shift    (rd_valid_reg),
            .load     (rd_load_reg),
            .is_tail  (DIM_W'(m + 1) == dim_reg),
            .next_val (nxt),
            .head_val (cell_val[0]),
            .feed_val (rd_data_reg),
            .val      (cell_val[m])
        );
    end

    apnn_dist #(.W(W), .MAX_DIM(MAX_DIM), .IW(IW)) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (rd_valid_reg && !rd_load_reg),
        .tag      (rd_tag_reg),
        .j        (rd_j_reg),
        .a        (rd_data_reg),
        .b        (cell_val[0]),
        .busy     (dist_busy),
        .best_idx (best_idx)
    );

    assign in_ready      = (state_reg == IDLE);
    assign out_valid     = out_valid_reg;
    assign source_index  = src_reg;
    assign nearest_index = near_reg;
    assign last_result   = last_result_reg;

    a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == OUT)
        else $error("result shown outside output state");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == IDLE |-> !dist_busy && !rd_valid_reg)
        else $error("distance pipeline active while idle");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(near_reg))
        else $error("pending result changed");

endmodule

// ===== rtl/core/apnn_cell.sv =====
module apnn_cell
    import apnn_pkg::*;
#(
    parameter int W = COMPONENT_BITS_DEF
) (
    input  logic                clk,
    input  logic                shift,
    input  logic                load,
    input  logic                is_tail,
    input  logic signed [W-1:0] next_val,
    input  logic signed [W-1:0] head_val,
    input  logic signed [W-1:0] feed_val,
    output logic signed [W-1:0] val
);

    logic signed [W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            if (is_tail)
                val_reg <= load ? feed_val : head_val;
            else
                val_reg <= next_val;
        end
    end

    assign val = val_reg;

endmodule

// ===== rtl/core/apnn_dist.sv =====
module apnn_dist
    import apnn_pkg::*;
#(
    parameter int W       = COMPONENT_BITS_DEF,
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int IW      = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  apnn_tag_t           tag,
    input  logic [IW-1:0]       j,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic                busy,
    output logic [IW-1:0]       best_idx
);

    localparam int DW    = W + 1;
    localparam int SQ_W  = 2 * DW;
    localparam int ACC_W = SQ_W + $clog2(MAX_DIM + 1);

    logic                 v1_reg, v2_reg;
    apnn_tag_t            t1_reg, t2_reg;
    logic [IW-1:0]        j1_reg, j2_reg;
    logic signed [DW-1:0] diff_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [ACC_W-1:0]     acc_reg, best_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [ACC_W-1:0]     total;
    logic signed [SQ_W-1:0] sq_full;

    assign sq_full = SQ_W'(diff_reg) * SQ_W'(diff_reg);
    assign total   = t2_reg.first_k ? ACC_W'(sq_reg) : acc_reg + ACC_W'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= tag;
        j1_reg   <= j;
        diff_reg <= DW'(a) - DW'(b);
        t2_reg   <= t1_reg;
        j2_reg   <= j1_reg;
        sq_reg   <= SQ_W'(sq_full);
        if (v2_reg)
        begin
            acc_reg <= total;
            if (t2_reg.last_k && (t2_reg.cand_first || total < best_reg))
            begin
                best_reg     <= total;
                best_idx_reg <= j2_reg;
            end
        end
    end

    assign busy     = v1_reg | v2_reg;
    assign best_idx = best_idx_reg;

endmodule

// ===== sim/apnn_checker.sv =====
module apnn_checker
    import apnn_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vector_dim_wr_en,
    input  logic [CFG_BITS-1:0]                vector_dim,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic signed [COMPONENT_BITS_DEF-1:0] component_value,
    input  logic                               last_component,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [5:0]                         source_index,
    input  logic [5:0]                         nearest_index,
    input  logic                               last_result,
    output int                                 fails,
    output int                                 pending,
    output int                                 results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_VECTORS_DEF * MAX_DIM_DEF;

    typedef struct {
        logic [5:0] src;
        logic [5:0] nearest;
        logic       last;
    } neighbour_t;

    logic signed [COMPONENT_BITS_DEF-1:0] component_store [STORE_DEPTH];
    logic [10:0]         stored_count;
    logic [CFG_BITS-1:0] dim_setting;
    neighbour_t          pending_neighbours [$];

    assign pending = pending_neighbours.size();

    function automatic longint unsigned sq_dist(int a, int b, int dim);
        longint unsigned acc;
        longint          d;
        acc = 0;
        for (int k = 0; k < dim; k++)
        begin
            d = longint'(component_store[a * dim + k]) - longint'(component_store[b * dim + k]);
            acc += longint'(d * d);
        end
        return acc;
    endfunction

    task automatic find_nearest();
        int              dim;
        int              nv;
        int              best_idx;
        longint unsigned best;
        longint unsigned s;
        neighbour_t      r;
        dim = (dim_setting == 0) ? 1 : (dim_setting > MAX_DIM_DEF ? MAX_DIM_DEF : dim_setting);
        nv  = stored_count / dim;
        if (nv > MAX_VECTORS_DEF)
            nv = MAX_VECTORS_DEF;
        for (int i = 0; i < nv; i++)
        begin
            best_idx = (i + 1) % nv;
            best     = sq_dist(i, best_idx, dim);
            for (int j = 0; j < nv; j++)
            begin
                if (j != i)
                begin
                    s = sq_dist(i, j, dim);
                    if (s < best)
                    begin
                        best     = s;
                        best_idx = j;
                    end
                end
            end
            r.src     = 6'(i);
            r.nearest = 6'(best_idx);
            r.last    = (i + 1 == nv);
            pending_neighbours.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        neighbour_t want;
        if (!rst_n)
        begin
            stored_count = 0;
            dim_setting  = 1;
            fails        = 0;
            results_seen = 0;
        end
        else
        begin
            if (vector_dim_wr_en)
                dim_setting = vector_dim;
            if (in_valid && in_ready)
            begin
                if (stored_count < STORE_DEPTH)
                begin
                    component_store[stored_count] = component_value;
                    stored_count++;
                end
                if (last_component)
                begin
                    find_nearest();
                    stored_count = 0;
                end
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_neighbours.size() == 0)
                    report_mismatch("unexpected word, source_index", source_index, -1);
                else
                begin
                    want = pending_neighbours.pop_front();
                    if (source_index !== want.src)
                        report_mismatch("source_index", source_index, want.src);
                    if (nearest_index !== want.nearest)
                        report_mismatch("nearest_index", nearest_index, want.nearest);
                    if (last_result !== want.last)
                        report_mismatch("last_result", last_result, want.last);
                end
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
module tb
    import apnn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic                                clk;
    logic                                rst_n;
    logic                                vector_dim_wr_en;
    logic [CFG_BITS-1:0]                 vector_dim;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [COMPONENT_BITS_DEF-1:0] component_value;
    logic                                last_component;
    logic                                out_valid;
    logic                                out_ready;
    logic [5:0]                          source_index;
    logic [5:0]                          nearest_index;
    logic                                last_result;

    int fails;
    int pending;
    int results_seen;
    int burst_left;
    int words_sent;
    int sets_sent;
    int idle_cycles = 0;
    int stall_tick;
    int stall_mode;

    all_pairs_nearest_neighbour i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .vector_dim_wr_en (vector_dim_wr_en),
        .vector_dim       (vector_dim),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .component_value  (component_value),
        .last_component   (last_component),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .source_index     (source_index),
        .nearest_index    (nearest_index),
        .last_result      (last_result)
    );

    apnn_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 0;
            stall_tick = 0;
            stall_mode = 0;
        end
        else
        begin
            stall_tick++;
            if (stall_tick % 97 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       out_ready <= 1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((stall_tick / 8) % 2 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= LIMIT)
        begin
            $display("all_pairs_nearest_neighbour test failed");
            $finish;
        end
    end

    task automatic send_word(input logic signed [15:0] v, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid        <= 1;
        component_value <= v;
        last_component  <= lst;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic hold_input();
        in_valid   <= 0;
        burst_left = 0;
        @(posedge clk);
    endtask

    task automatic write_dim(input int v);
        vector_dim_wr_en <= 1;
        vector_dim       <= CFG_BITS'(v);
        @(posedge clk);
        vector_dim_wr_en <= 0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        hold_input();
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_value(int mode, int n);
        case (mode)
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 6)) - 3);
            2:       return 16'sd1234;
            default: return n % 2 ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task automatic send_set(input int ncomp, input int mode);
        for (int n = 0; n < ncomp; n++)
            send_word(pick_value(mode, n), n == ncomp - 1);
        sets_sent++;
    endtask

    initial
    begin
        int dim;
        int nv;
        int extra;
        rst_n            = 0;
        vector_dim_wr_en = 0;
        vector_dim       = 1;
        in_valid         = 0;
        component_value  = 0;
        last_component   = 0;
        burst_left       = 0;
        words_sent       = 0;
        sets_sent        = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // single vector at reset dimension
        send_set(1, 0);
        wait_idle();
        write_dim(0);
        send_set(4, 0);
        wait_idle();
        write_dim(2);
        send_set(6, 3);
        wait_idle();
        write_dim(3);
        send_set(9, 2);
        wait_idle();
        write_dim(4);
        send_set(3, 0);
        wait_idle();
        // regroup with dimension written mid-set
        write_dim(2);
        for (int n = 0; n < 3; n++)
            send_word(16'($urandom), 0);
        hold_input();
        write_dim(3);
        send_set(3, 0);
        wait_idle();
        write_dim(31);
        send_set(20, 0);
        wait_idle();
        // more vectors than fit
        write_dim(1);
        send_set(70, 0);
        wait_idle();

        while (words_sent < 330)
        begin
            case ($urandom_range(0, 9))
                0:       dim = 0;
                1:       dim = $urandom_range(17, 31);
                2:       dim = 16;
                3:       dim = $urandom_range(7, 15);
                default: dim = $urandom_range(1, 6);
            endcase
            write_dim(dim);
            if (dim == 0)
                dim = 1;
            if (dim > 16)
                dim = 16;
            nv    = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, dim - 1) : 0;
            if (nv * dim + extra == 0)
                extra = 1;
            send_set(nv * dim + extra, $urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 3));
            wait_idle();
        end

        $display("Sent %0d components in %0d sets, checked %0d neighbour results.",
                 words_sent, sets_sent, results_seen);
        if (fails == 0 && pending == 0)
            $display("all_pairs_nearest_neighbour test passed");
        else
            $display("all_pairs_nearest_neighbour test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/apnn_pkg.sv
rtl/core/apnn_cell.sv
rtl/core/apnn_dist.sv
rtl/core/all_pairs_nearest_neighbour.sv
sim/apnn_checker.sv
sim/tb.sv
